>>> rtl/depth_pixel_back_projection_assert.svh
// Assertion macros used by the back-projection top level.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DPBP_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DPBP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/dpbp_pkg.sv
// Types, constants and register map of the depth pixel back-projection block.
package dpbp_pkg;

    localparam int COORD_BITS = 12;
    localparam int CENTER_W   = 13;
    localparam int INV_W      = 24;
    localparam int INV_HALF   = INV_W / 2;
    localparam int SCALE_W    = 16;
    localparam int DEPTH_W    = 16;
    localparam int Z_W        = 24;
    localparam int FRAC_SHIFT = 8;
    localparam int OUT_W      = 32;
    localparam int MAG_W      = (COORD_BITS + 1 > CENTER_W) ? COORD_BITS + 1 : CENTER_W;
    localparam int MZ_W       = MAG_W + Z_W;
    localparam int PART_W     = MZ_W + INV_HALF;
    // final scaling is 2^25: 12 bits dropped in the partial-product sum, 13 after
    localparam int TAIL_SHIFT = 25 - INV_HALF;
    localparam int Q_W        = PART_W - TAIL_SHIFT;

    localparam int STAGES = 5;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_INV_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_INV_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_X2   = 3'd2;
    localparam logic [2:0] REG_CENTER_Y2   = 3'd3;
    localparam logic [2:0] REG_DEPTH_SCALE = 3'd4;

    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X = 24'd31957;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y = 24'd31957;
    localparam logic [CENTER_W-1:0] RST_CENTER_X2   = 13'd639;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y2   = 13'd479;
    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 16'd256;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth_mm;
        logic [7:0]            red_in;
        logic [7:0]            green_in;
        logic [7:0]            blue_in;
    } pixel_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic [Z_W-1:0]          point_z;
        logic [7:0]              red_out;
        logic [7:0]              green_out;
        logic [7:0]              blue_out;
    } point_t;

    // per-stage load enables, stage 0 first
    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctrl_t;

endpackage

>>> rtl/dpbp_lateral.sv
// One lateral axis: centre offset, depth product, reciprocal product, floor and saturate.
module dpbp_lateral (
    input  logic                                  clk,
    input  dpbp_pkg::pipe_ctrl_t                  ctrl,
    input  logic [dpbp_pkg::COORD_BITS-1:0]       coord,
    input  logic [dpbp_pkg::CENTER_W-1:0]         center2,
    input  logic [dpbp_pkg::INV_W-1:0]            inv,
    input  logic [dpbp_pkg::Z_W-1:0]              z_s0,
    output logic signed [dpbp_pkg::OUT_W-1:0]     result
);
    import dpbp_pkg::*;

    logic [MAG_W-1:0]  twice;
    logic [MAG_W-1:0]  centre_ext;
    logic              neg_next;
    logic [MAG_W-1:0]  mag_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [MZ_W-1:0]   mz_reg;
    logic [PART_W-1:0] hi_reg;
    logic [PART_W-1:0] lo_reg;
    logic [PART_W-1:0] sum_next;
    logic [Q_W-1:0]    q_reg;
    logic              rem_reg;
    logic [3:0]        neg_reg;
    logic [Q_W:0]      qn;
    logic [OUT_W-1:0]  res_next;
    logic [OUT_W-1:0]  res_reg;

    // stage 0: signed offset from the centre, as sign and magnitude
    assign twice      = MAG_W'({coord, 1'b0});
    assign centre_ext = MAG_W'(center2);
    assign neg_next   = twice < centre_ext;
    assign mag_next   = neg_next ? (centre_ext - twice) : (twice - centre_ext);

    // stage 3: floor(P / 2^12) from the two partial products
    assign sum_next = hi_reg + PART_W'(lo_reg[PART_W-1:INV_HALF]);

    // stage 4: saturate; negatives round toward minus infinity
    always_comb
    begin
        qn = {1'b0, q_reg} + (Q_W+1)'(rem_reg);
        if (!neg_reg[3])
        begin
            if (q_reg > Q_W'(32'h7FFF_FFFF))
                res_next = 32'h7FFF_FFFF;
            else
                res_next = q_reg[OUT_W-1:0];
        end
        else
        begin
            if (qn > (Q_W+1)'(33'h0_8000_0000))
                res_next = 32'h8000_0000;
            else
                res_next = (~qn[OUT_W-1:0]) + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            mag_reg    <= mag_next;
            neg_reg[0] <= neg_next;
        end
        if (ctrl.en[1])
        begin
            mz_reg     <= mag_reg * z_s0;
            neg_reg[1] <= neg_reg[0];
        end
        if (ctrl.en[2])
        begin
            hi_reg     <= mz_reg * inv[INV_W-1:INV_HALF];
            lo_reg     <= mz_reg * inv[INV_HALF-1:0];
            neg_reg[2] <= neg_reg[1];
        end
        if (ctrl.en[3])
        begin
            q_reg      <= sum_next[PART_W-1:TAIL_SHIFT];
            rem_reg    <= (|sum_next[TAIL_SHIFT-1:0]) || (|lo_reg[INV_HALF-1:0]);
            neg_reg[3] <= neg_reg[2];
        end
        if (ctrl.en[4])
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

>>> rtl/depth_pixel_back_projection.sv
// Top level: pinhole back-projection of depth pixels into coloured 3D points.
// Pipeline: point_valid rises once the pixel has moved through the five register stages,
// the first of which is loaded at the pixel transfer edge.
// Throughput: one pixel per cycle; a stage loads when empty or when its successor loads,
// so only a stalled output register holds the pipe and refuses pixels.
// Reset: rst_n asynchronous active low; clears stage valid bits and loads the
// register defaults (inv focal 31957, centre 639/479, depth scale 256).
`include "depth_pixel_back_projection_assert.svh"

module depth_pixel_back_projection (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel channel
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  dpbp_pkg::pixel_t                pixel,
    // point channel
    output logic                            point_valid,
    input  logic                            point_ready,
    output dpbp_pkg::point_t                point,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpbp_pkg::PADDR_W-1:0]    paddr,
    input  logic [dpbp_pkg::PDATA_W-1:0]    pwdata,
    output logic [dpbp_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import dpbp_pkg::*;

    // ---------------------------------------------------------------------
    // Register file. Writes land in the access phase; pready is tied high.
    // ---------------------------------------------------------------------
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;
    logic [CENTER_W-1:0] center_x2_reg;
    logic [CENTER_W-1:0] center_y2_reg;
    logic [SCALE_W-1:0]  depth_scale_reg;
    logic [2:0]          reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= RST_INV_FOCAL_X;
            inv_focal_y_reg <= RST_INV_FOCAL_Y;
            center_x2_reg   <= RST_CENTER_X2;
            center_y2_reg   <= RST_CENTER_Y2;
            depth_scale_reg <= RST_DEPTH_SCALE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_INV_FOCAL_X: inv_focal_x_reg <= pwdata[INV_W-1:0];
                REG_INV_FOCAL_Y: inv_focal_y_reg <= pwdata[INV_W-1:0];
                REG_CENTER_X2:   center_x2_reg   <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y2:   center_y2_reg   <= pwdata[CENTER_W-1:0];
                REG_DEPTH_SCALE: depth_scale_reg <= pwdata[SCALE_W-1:0];
                default:         ; // unmapped addresses ignore the write
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INV_FOCAL_X: prdata = PDATA_W'(inv_focal_x_reg);
            REG_INV_FOCAL_Y: prdata = PDATA_W'(inv_focal_y_reg);
            REG_CENTER_X2:   prdata = PDATA_W'(center_x2_reg);
            REG_CENTER_Y2:   prdata = PDATA_W'(center_y2_reg);
            REG_DEPTH_SCALE: prdata = PDATA_W'(depth_scale_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Pipeline control. A stage loads when it is empty or its successor loads; the last
    // stage is the output register, freed by a point transfer. The user must keep the
    // registers static while items are in flight; the block does not enforce it.
    // ---------------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    pipe_ctrl_t        ctrl;

    always_comb
    begin
        ctrl.en[STAGES-1] = !vld_reg[STAGES-1] || point_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            ctrl.en[k] = !vld_reg[k] || ctrl.en[k+1];
    end

    assign pixel_ready = ctrl.en[0];
    assign point_valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ctrl.en[0])
                vld_reg[0] <= pixel_valid;
            for (int k = 1; k < STAGES; k++)
                if (ctrl.en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------------------------------------------------------------
    // Depth path: Z = depth * Q8.8 scale, truncated. Colour and Z ride
    // alongside the lateral pipelines to the output register.
    // ---------------------------------------------------------------------
    logic [DEPTH_W+SCALE_W-1:0] z_prod;
    logic [Z_W-1:0]             z_reg   [STAGES];
    logic [7:0]                 red_reg [STAGES];
    logic [7:0]                 grn_reg [STAGES];
    logic [7:0]                 blu_reg [STAGES];

    assign z_prod = pixel.depth_mm * depth_scale_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            z_reg[0]   <= z_prod[FRAC_SHIFT+Z_W-1:FRAC_SHIFT];
            red_reg[0] <= pixel.red_in;
            grn_reg[0] <= pixel.green_in;
            blu_reg[0] <= pixel.blue_in;
        end
        for (int k = 1; k < STAGES; k++)
            if (ctrl.en[k])
            begin
                z_reg[k]   <= z_reg[k-1];
                red_reg[k] <= red_reg[k-1];
                grn_reg[k] <= grn_reg[k-1];
                blu_reg[k] <= blu_reg[k-1];
            end
    end

    // ---------------------------------------------------------------------
    // Lateral axes: X from column, Y from row.
    // ---------------------------------------------------------------------
    logic signed [OUT_W-1:0] x_res;
    logic signed [OUT_W-1:0] y_res;

    dpbp_lateral u_lat_x (
        .clk     (clk),
        .ctrl    (ctrl),
        .coord   (pixel.column),
        .center2 (center_x2_reg),
        .inv     (inv_focal_x_reg),
        .z_s0    (z_reg[0]),
        .result  (x_res)
    );

    dpbp_lateral u_lat_y (
        .clk     (clk),
        .ctrl    (ctrl),
        .coord   (pixel.row),
        .center2 (center_y2_reg),
        .inv     (inv_focal_y_reg),
        .z_s0    (z_reg[0]),
        .result  (y_res)
    );

    assign point.point_x   = x_res;
    assign point.point_y   = y_res;
    assign point.point_z   = z_reg[STAGES-1];
    assign point.red_out   = red_reg[STAGES-1];
    assign point.green_out = grn_reg[STAGES-1];
    assign point.blue_out  = blu_reg[STAGES-1];

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // pixels are refused only when the whole chain is blocked at the output
    `DPBP_ASSERT_SAME(a_ready_only_when_blocked, clk, rst_n, !pixel_ready,
        point_valid && !point_ready, "pixel_ready low without output stall")
    // a full pipeline behind a stalled output cannot take another pixel
    `DPBP_ASSERT_SAME(a_full_refuses, clk, rst_n, (&vld_reg) && !point_ready,
        !pixel_ready, "full pipeline accepted a pixel")
    // zero depth gives the origin on both lateral axes
    `DPBP_ASSERT_SAME(a_zero_depth_origin, clk, rst_n,
        point_valid && (point.point_z == '0),
        (point.point_x == '0) && (point.point_y == '0), "non-zero X/Y at zero depth")

endmodule

>>> bench/depth_pixel_back_projection_check.sv
`timescale 1ns / 100ps
// Scoreboard for the back-projection block: mirrors the registers, predicts each point, compares.
module depth_pixel_back_projection_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    input  logic                            pixel_ready,
    input  dpbp_pkg::pixel_t                pixel,
    input  logic                            point_valid,
    input  logic                            point_ready,
    input  dpbp_pkg::point_t                point,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [dpbp_pkg::PADDR_W-1:0]    paddr,
    input  logic [dpbp_pkg::PDATA_W-1:0]    pwdata,
    output int                              mismatches,
    output int                              outstanding
);
    import dpbp_pkg::*;

    localparam logic signed [79:0] LAT_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] LAT_MIN = -80'sh8000_0000;

    logic [INV_W-1:0]    inv_fx;
    logic [INV_W-1:0]    inv_fy;
    logic [CENTER_W-1:0] centre_x2;
    logic [CENTER_W-1:0] centre_y2;
    logic [SCALE_W-1:0]  scale_q8;

    point_t expected_points[$];

    // floor(offset * z * inv / 2^25), clamped to 32-bit signed
    function automatic logic [OUT_W-1:0] lateral_mm(input logic [COORD_BITS-1:0] coord,
                                                    input logic [CENTER_W-1:0] centre2,
                                                    input logic [Z_W-1:0] z,
                                                    input logic [INV_W-1:0] inv);
        logic signed [79:0] offset;
        logic signed [79:0] prod;
        logic signed [79:0] q;
        offset = $signed({67'd0, coord, 1'b0}) - $signed({67'd0, centre2});
        prod = offset * $signed({56'd0, z}) * $signed({56'd0, inv});
        q = prod >>> 25;
        if (q > LAT_MAX)
            return LAT_MAX[OUT_W-1:0];
        if (q < LAT_MIN)
            return LAT_MIN[OUT_W-1:0];
        return q[OUT_W-1:0];
    endfunction

    function automatic point_t project(input pixel_t px);
        point_t p;
        logic [31:0] z_full;
        z_full = px.depth_mm * scale_q8;
        p.point_z   = z_full[31:FRAC_SHIFT];
        p.point_x   = lateral_mm(px.column, centre_x2, p.point_z, inv_fx);
        p.point_y   = lateral_mm(px.row, centre_y2, p.point_z, inv_fy);
        p.red_out   = px.red_in;
        p.green_out = px.green_in;
        p.blue_out  = px.blue_in;
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        point_t want;
        if (!rst_n) begin
            inv_fx    <= RST_INV_FOCAL_X;
            inv_fy    <= RST_INV_FOCAL_Y;
            centre_x2 <= RST_CENTER_X2;
            centre_y2 <= RST_CENTER_Y2;
            scale_q8  <= RST_DEPTH_SCALE;
            expected_points.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_INV_FOCAL_X: inv_fx    <= pwdata[INV_W-1:0];
                    REG_INV_FOCAL_Y: inv_fy    <= pwdata[INV_W-1:0];
                    REG_CENTER_X2:   centre_x2 <= pwdata[CENTER_W-1:0];
                    REG_CENTER_Y2:   centre_y2 <= pwdata[CENTER_W-1:0];
                    REG_DEPTH_SCALE: scale_q8  <= pwdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            // a point can never stem from a pixel taken at the same edge
            if (point_valid && point_ready) begin
                if (expected_points.size() == 0) begin
                    $error("point transfer with no pixel outstanding");
                    mismatches++;
                end
                else begin
                    want = expected_points.pop_front();
                    check_field("point_x", want.point_x, point.point_x);
                    check_field("point_y", want.point_y, point.point_y);
                    check_field("point_z", 32'(want.point_z), 32'(point.point_z));
                    check_field("red_out", 32'(want.red_out), 32'(point.red_out));
                    check_field("green_out", 32'(want.green_out), 32'(point.green_out));
                    check_field("blue_out", 32'(want.blue_out), 32'(point.blue_out));
                end
            end
            if (pixel_valid && pixel_ready)
                expected_points.push_back(project(pixel));
            outstanding = expected_points.size();
        end
    end

endmodule

>>> bench/depth_pixel_back_projection_test.sv
`timescale 1ns / 100ps
// Top of the back-projection bench: clock, reset, pixel and register stimulus, verdict.
module depth_pixel_back_projection_test;
    import dpbp_pkg::*;

    localparam int PIXELS_PER_PHASE = 150;
    localparam int RANDOM_PHASES    = 6;
    localparam int BURST_PHASE      = 2;   // no idling on either side
    localparam int HOLD_PHASE       = 4;   // receiver backs off, sender keeps pushing
    localparam int HOLD_CYCLES      = 80;
    localparam int HOLD_PIXELS      = 40;
    localparam int SETTLE_CYCLES    = STAGES * 4;
    // generous: ~1000 pixels, each at worst a long sender gap plus a long receiver stall
    localparam int CYCLE_LIMIT      = 400000;

    // address slot with no register behind it; writes there must be ignored
    localparam logic [2:0] REG_RESERVED = 3'd5;

    logic                clk;
    logic                rst_n;
    logic                pixel_valid;
    logic                pixel_ready;
    pixel_t              pixel;
    logic                point_valid;
    logic                point_ready;
    point_t              point;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int mismatches;
    int outstanding;

    // shared between the pixel driver and the point sink
    bit burst_mode;
    bit hold_request;

    depth_pixel_back_projection u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    depth_pixel_back_projection_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("depth_pixel_back_projection_test NOT OK");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic pixel_t make_pixel(input logic [COORD_BITS-1:0] col,
                                          input logic [COORD_BITS-1:0] row,
                                          input logic [DEPTH_W-1:0] depth,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        pixel_t px;
        px.column   = col;
        px.row      = row;
        px.depth_mm = depth;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        return px;
    endfunction

    // Full-range coordinates and colour; depth leans a little towards zero and full scale.
    function automatic pixel_t random_pixel();
        logic [DEPTH_W-1:0] depth;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            depth = '0;
        else if (r == 1)
            depth = '1;
        else
            depth = DEPTH_W'($urandom_range(0, 65535));
        return make_pixel(COORD_BITS'($urandom_range(0, 4095)),
                          COORD_BITS'($urandom_range(0, 4095)), depth,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
    endfunction

    // Reciprocal focal length: typical camera values, anything, or the extreme.
    function automatic logic [INV_W-1:0] random_inv();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return INV_W'($urandom_range(1, 24'hFF_FFFF));
        if (r == 1)
            return '1;
        return INV_W'($urandom_range(20000, 60000));
    endfunction

    function automatic logic [CENTER_W-1:0] random_centre();
        if ($urandom_range(0, 1))
            return CENTER_W'($urandom_range(0, 8191));
        return CENTER_W'($urandom_range(400, 1400));
    endfunction

    function automatic logic [SCALE_W-1:0] random_scale();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return SCALE_W'($urandom_range(0, 65535));
        if (r == 1)
            return RST_DEPTH_SCALE;
        return SCALE_W'($urandom_range(100, 1200));
    endfunction

    // One pixel transfer: optional idle cycles, then hold valid until taken.
    task automatic send_pixel(input pixel_t px, input int gap);
        repeat (gap) begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel       <= px;
        do @(posedge clk); while (!pixel_ready);
    endtask

    // Setup cycle, then access cycle; the register is written at the access edge.
    task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Loads all five registers; junk in the unused upper bits must be dropped.
    task automatic load_settings(input logic [INV_W-1:0] ix, input logic [INV_W-1:0] iy,
                                 input logic [CENTER_W-1:0] cx,
                                 input logic [CENTER_W-1:0] cy,
                                 input logic [SCALE_W-1:0] sc);
        logic [31:0] junk;
        junk = $urandom;
        apb_write(REG_INV_FOCAL_X, {junk[31:24], ix});
        apb_write(REG_INV_FOCAL_Y, {junk[23:16], iy});
        apb_write(REG_CENTER_X2, {junk[31:13], cx});
        apb_write(REG_CENTER_Y2, {junk[18:0], cy});
        apb_write(REG_DEPTH_SCALE, {junk[15:0], sc});
    endtask

    // Stop offering pixels and wait for every predicted point to come out.
    task automatic drain_points();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (STAGES) @(negedge clk);
    endtask

    // Point sink: random runs of ready and back-pressure, a long hold on request.
    initial begin
        int gap;
        int run;
        point_ready = 1'b0;
        forever begin
            if (hold_request) begin
                // long back-off, counted here while the driver keeps pushing
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    point_ready <= 1'b0;
                end
                hold_request = 1'b0;
            end
            else begin
                gap = pick_gap();
                run = burst_mode ? 1 : $urandom_range(1, 12);
                repeat (gap) begin
                    @(negedge clk);
                    point_ready <= 1'b0;
                end
                repeat (run) begin
                    @(negedge clk);
                    point_ready <= 1'b1;
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        int phase;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        burst_mode   = 1'b0;
        hold_request = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero depth, field extremes, a pixel either side of the centre
        // (the one just left of it must round towards minus infinity), alternating bits.
        send_pixel(make_pixel(12'd0, 12'd0, 16'd0, 8'd0, 8'd0, 8'd0), pick_gap());
        send_pixel(make_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF), pick_gap());
        send_pixel(make_pixel(12'd0, 12'd0, 16'hFFFF, 8'h00, 8'h00, 8'h00), pick_gap());
        send_pixel(make_pixel(12'd319, 12'd239, 16'd1000, 8'h12, 8'h34, 8'h56), pick_gap());
        send_pixel(make_pixel(12'd320, 12'd240, 16'd1000, 8'h65, 8'h43, 8'h21), pick_gap());
        send_pixel(make_pixel(12'h555, 12'hAAA, 16'hAAAA, 8'h55, 8'hAA, 8'h55), pick_gap());
        send_pixel(make_pixel(12'hAAA, 12'h555, 16'h5555, 8'hAA, 8'h55, 8'hAA), pick_gap());
        drain_points();

        // Widest reciprocal and scale, centres at both ends: X and Y saturate
        // towards opposite bounds. Also a write to the empty slot.
        load_settings('1, '1, '1, '0, '1);
        apb_write(REG_RESERVED, $urandom);
        send_pixel(make_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'h01, 8'h02, 8'h03), pick_gap());
        send_pixel(make_pixel(12'hFFF, 12'd0, 16'hFFFF, 8'h80, 8'h40, 8'h20), pick_gap());
        send_pixel(make_pixel(12'd0, 12'd0, 16'd0, 8'hFE, 8'hFD, 8'hFB), pick_gap());
        send_pixel(make_pixel(12'hFFF, 12'hFFF, 16'd1, 8'h7F, 8'hBF, 8'hDF), pick_gap());
        drain_points();

        // Zero reciprocal on X: lateral product vanishes, no fault.
        load_settings('0, 24'd1, '0, '1, RST_DEPTH_SCALE);
        send_pixel(make_pixel(12'hFFF, 12'd0, 16'hFFFF, 8'h11, 8'h22, 8'h33), pick_gap());
        send_pixel(make_pixel(12'd100, 12'd200, 16'd300, 8'h44, 8'h55, 8'h66), pick_gap());
        drain_points();

        // Zero scale: Z and both lateral terms vanish whatever the depth.
        load_settings(24'd1, '0, '1, '0, '0);
        send_pixel(make_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'h77, 8'h88, 8'h99), pick_gap());
        send_pixel(make_pixel(12'd2048, 12'd2048, 16'd40000, 8'hCC, 8'hDD, 8'hEE), pick_gap());
        drain_points();

        // Random phases, each under fresh settings and fully drained before the next
        // register write. One phase runs with no idling at all; in another the sink
        // backs off for a long stretch while pixels keep coming, so the pipe fills
        // and pixel_ready drops.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_settings(random_inv(), random_inv(), random_centre(), random_centre(),
                          random_scale());
            burst_mode = (phase == BURST_PHASE);
            if (phase == HOLD_PHASE) begin
                hold_request = 1'b1;
                repeat (HOLD_PIXELS) send_pixel(random_pixel(), 0);
            end
            repeat (PIXELS_PER_PHASE) send_pixel(random_pixel(), pick_gap());
            drain_points();
        end
        burst_mode = 1'b0;

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("depth_pixel_back_projection_test OK");
        else
            $display("depth_pixel_back_projection_test NOT OK");
        $finish;
    end

endmodule
